// ===== hw/rtl/csed_pkg.sv =====
`default_nettype none

package csed_pkg;

  // decoder phase
  typedef enum logic [2:0] {
    PhIdle,
    PhDigits,
    PhBody,
    PhCaret,
    PhBsl,
    PhOct1,
    PhOct2
  } phase_e;

  // per-string decode state
  typedef struct packed {
    phase_e     phase;
    logic [6:0] delay_count;
    logic [7:0] octal_value;
  } state_t;

  // one decoded result
  typedef struct packed {
    logic [7:0] out_byte;
    logic [6:0] pad_count;
    logic       end_of_string;
    logic       last_of_item;
  } result_t;

  // character codes
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChColon     = 8'h3A;
  localparam logic [7:0] ChCaret     = 8'h5E;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChUpperE    = 8'h45;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;

  // control byte values
  localparam logic [7:0] CtlEsc = 8'h1B;
  localparam logic [7:0] CtlLf  = 8'h0A;
  localparam logic [7:0] CtlCr  = 8'h0D;
  localparam logic [7:0] CtlTab = 8'h09;
  localparam logic [7:0] CtlBs  = 8'h08;
  localparam logic [7:0] CtlFf  = 8'h0C;

  localparam logic [7:0] CaretMask = 8'h1F;
  localparam logic [6:0] DelayMax  = 7'd127;

  // result queue geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  // backslash escape map; characters without an entry stand for themselves
  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      ChUpperE: r = CtlEsc;
      ChLowerN: r = CtlLf;
      ChLowerR: r = CtlCr;
      ChLowerT: r = CtlTab;
      ChLowerB: r = CtlBs;
      ChLowerF: r = CtlFf;
      default:  r = c;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/csed_decode.sv =====
`default_nettype none

module csed_decode (
  input  csed_pkg::state_t  state_i,
  input  logic [7:0]        ch_i,
  input  logic              start_i,
  input  logic [6:0]        pad_limit_i,
  output csed_pkg::state_t  state_o,
  output logic [1:0]        n_res_o,
  output csed_pkg::result_t res0_o,
  output csed_pkg::result_t res1_o
);

  csed_pkg::state_t  eff;
  csed_pkg::result_t term_res;
  csed_pkg::result_t body_res;
  csed_pkg::phase_e  body_phase;
  logic              body_emit;
  logic              body_term;
  logic              is_digit;
  logic [7:0]        ch_off;
  logic [10:0]       delay_sum;
  logic [7:0]        oct_shift;
  logic [1:0]        n_res;

  // a start mark opens a new string
  always_comb begin
    if (start_i) begin
      eff.phase       = csed_pkg::PhDigits;
      eff.delay_count = '0;
      eff.octal_value = '0;
    end else begin
      eff = state_i;
    end
  end

  assign is_digit  = (ch_i >= csed_pkg::ChZero) && (ch_i <= csed_pkg::ChNine);
  assign ch_off    = ch_i - csed_pkg::ChZero;
  assign delay_sum = {4'b0, eff.delay_count} * 11'd10 + {7'b0, ch_off[3:0]};
  assign oct_shift = {eff.octal_value[4:0], 3'b000};

  // terminator result with clamped padding
  always_comb begin
    term_res.out_byte      = '0;
    term_res.pad_count     = (eff.delay_count < pad_limit_i) ? eff.delay_count : pad_limit_i;
    term_res.end_of_string = 1'b1;
    term_res.last_of_item  = 1'b0;
  end

  // plain body character handling
  always_comb begin
    body_term  = (ch_i == csed_pkg::ChNul) || (ch_i == csed_pkg::ChColon);
    body_emit  = 1'b0;
    body_phase = csed_pkg::PhBody;
    body_res   = term_res;
    if (body_term) begin
      body_emit  = 1'b1;
      body_phase = csed_pkg::PhIdle;
    end else if (ch_i == csed_pkg::ChCaret) begin
      body_phase = csed_pkg::PhCaret;
    end else if (ch_i == csed_pkg::ChBackslash) begin
      body_phase = csed_pkg::PhBsl;
    end else begin
      body_emit              = 1'b1;
      body_res.out_byte      = ch_i;
      body_res.pad_count     = '0;
      body_res.end_of_string = 1'b0;
    end
  end

  // phase transitions and results
  always_comb begin
    state_o = eff;
    n_res   = 2'd0;
    res0_o  = term_res;
    res1_o  = term_res;
    unique case (eff.phase)
      csed_pkg::PhIdle: begin
        state_o.phase = csed_pkg::PhIdle;
      end
      csed_pkg::PhDigits: begin
        if (is_digit) begin
          state_o.delay_count = (delay_sum > 11'd127) ? csed_pkg::DelayMax : delay_sum[6:0];
        end else begin
          state_o.phase = body_phase;
          res0_o        = body_res;
          n_res         = body_emit ? 2'd1 : 2'd0;
          if (body_term) begin
            state_o.delay_count = '0;
            state_o.octal_value = '0;
          end
        end
      end
      csed_pkg::PhBody: begin
        state_o.phase = body_phase;
        res0_o        = body_res;
        n_res         = body_emit ? 2'd1 : 2'd0;
        if (body_term) begin
          state_o.delay_count = '0;
          state_o.octal_value = '0;
        end
      end
      csed_pkg::PhCaret: begin
        n_res = 2'd1;
        if (ch_i == csed_pkg::ChNul) begin
          state_o.phase       = csed_pkg::PhIdle;
          state_o.delay_count = '0;
          state_o.octal_value = '0;
        end else begin
          state_o.phase          = csed_pkg::PhBody;
          res0_o.out_byte        = ch_i & csed_pkg::CaretMask;
          res0_o.pad_count       = '0;
          res0_o.end_of_string   = 1'b0;
        end
      end
      csed_pkg::PhBsl: begin
        if (ch_i == csed_pkg::ChNul) begin
          n_res               = 2'd1;
          state_o.phase       = csed_pkg::PhIdle;
          state_o.delay_count = '0;
          state_o.octal_value = '0;
        end else if (is_digit) begin
          state_o.phase       = csed_pkg::PhOct1;
          state_o.octal_value = ch_off;
        end else begin
          n_res                = 2'd1;
          state_o.phase        = csed_pkg::PhBody;
          res0_o.out_byte      = csed_pkg::esc_map(ch_i);
          res0_o.pad_count     = '0;
          res0_o.end_of_string = 1'b0;
        end
      end
      csed_pkg::PhOct1: begin
        if (ch_i == csed_pkg::ChNul) begin
          n_res               = 2'd1;
          state_o.phase       = csed_pkg::PhIdle;
          state_o.delay_count = '0;
          state_o.octal_value = '0;
        end else begin
          state_o.phase       = csed_pkg::PhOct2;
          state_o.octal_value = oct_shift | ch_off;
        end
      end
      csed_pkg::PhOct2: begin
        n_res                = 2'd1;
        res0_o.pad_count     = '0;
        res0_o.end_of_string = 1'b0;
        if (is_digit) begin
          state_o.phase       = csed_pkg::PhBody;
          state_o.octal_value = oct_shift | ch_off;
          res0_o.out_byte     = oct_shift | ch_off;
        end else begin
          // octal byte first, then the character decoded as body text
          res0_o.out_byte = eff.octal_value;
          state_o.phase   = body_phase;
          res1_o          = body_res;
          n_res           = body_emit ? 2'd2 : 2'd1;
          if (body_term) begin
            state_o.delay_count = '0;
            state_o.octal_value = '0;
          end
        end
      end
      default: begin
        state_o.phase = csed_pkg::PhIdle;
      end
    endcase
    res0_o.last_of_item = (n_res == 2'd1);
    res1_o.last_of_item = 1'b1;
  end

  assign n_res_o = n_res;

endmodule

`default_nettype wire

// ===== hw/rtl/csed_out_fifo.sv =====
`default_nettype none

module csed_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_cnt_i,
  input  csed_pkg::result_t push0_i,
  input  csed_pkg::result_t push1_i,
  input  logic              pop_i,
  output csed_pkg::result_t head_o,
  output logic              valid_o,
  output logic              room_o
);

  csed_pkg::result_t                     mem_q [csed_pkg::FifoDepth];
  logic [csed_pkg::FifoPtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [csed_pkg::FifoPtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [csed_pkg::FifoCntW-1:0]         count_q, count_d;
  logic [csed_pkg::FifoPtrW-1:0]         wr_ptr_nx;
  logic                                  do_pop;

  assign valid_o   = (count_q != '0);
  assign room_o    = (count_q <= csed_pkg::FifoCntW'(csed_pkg::FifoDepth - 2));
  assign head_o    = mem_q[rd_ptr_q];
  assign do_pop    = pop_i && valid_o;
  assign wr_ptr_nx = wr_ptr_q + 1'b1;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q + push_cnt_i;
    rd_ptr_d = rd_ptr_q + {{(csed_pkg::FifoPtrW-1){1'b0}}, do_pop};
    count_d  = count_q + {{(csed_pkg::FifoCntW-2){1'b0}}, push_cnt_i}
             - {{(csed_pkg::FifoCntW-1){1'b0}}, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // up to two writes per cycle
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push1_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/capability_string_escape_decoder.sv =====
`default_nettype none

// Decodes terminal capability string text, one character per input transfer
// (tuser marks the first character of a string), into the bytes it stands
// for: leading delay digits, ^X controls, backslash escapes and octal values,
// with a terminator result (tlast) that carries the clamped padding count.
// An accepted character passes through one input register, is decoded
// combinationally and its zero, one or two results are written to a
// four-entry result queue; the block takes a new character every cycle
// while the queue has room for two results. Results leave at one per
// cycle while the receiver is ready; the first result is offered on the
// output once its character has left the input register and been written
// to the result queue.

module capability_string_escape_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pad_limit_we_i,
  input  logic [6:0]  pad_limit_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [14:8] pad_count, [15] zero
  output logic        m_axis_tlast,   // end_of_string
  output logic        m_axis_tuser    // [0] last_of_item
);

  logic [6:0]        pad_limit_q;
  logic              in_valid_q, in_valid_d;
  logic [7:0]        ch_q;
  logic              start_q;
  csed_pkg::state_t  state_q, state_d, dec_state;
  logic [1:0]        dec_n_res;
  csed_pkg::result_t dec_res0, dec_res1, head;
  logic              fifo_valid, fifo_room;
  logic              advance, s_xfer;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_limit_q <= 7'd100;
    end else if (pad_limit_we_i) begin
      pad_limit_q <= pad_limit_i;
    end
  end

  // input register handshake
  assign advance       = in_valid_q && fifo_room;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      ch_q    <= s_axis_tdata;
      start_q <= s_axis_tuser;
    end
  end

  // decode state
  assign state_d = advance ? dec_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= csed_pkg::PhIdle;
      state_q.delay_count <= '0;
      state_q.octal_value <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  csed_decode u_decode (
    .state_i     (state_q),
    .ch_i        (ch_q),
    .start_i     (start_q),
    .pad_limit_i (pad_limit_q),
    .state_o     (dec_state),
    .n_res_o     (dec_n_res),
    .res0_o      (dec_res0),
    .res1_o      (dec_res1)
  );

  csed_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (advance ? dec_n_res : 2'd0),
    .push0_i    (dec_res0),
    .push1_i    (dec_res1),
    .pop_i      (m_axis_tready),
    .head_o     (head),
    .valid_o    (fifo_valid),
    .room_o     (fifo_room)
  );

  // output transfer
  assign m_axis_tvalid = fifo_valid;
  assign m_axis_tdata  = {1'b0, head.pad_count, head.out_byte};
  assign m_axis_tlast  = head.end_of_string;
  assign m_axis_tuser  = head.last_of_item;

  // checks
  a_term_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (dec_n_res != 2'd0) &&
     ((dec_n_res == 2'd1) ? dec_res0.end_of_string : dec_res1.end_of_string))
    |=> (state_q.phase == csed_pkg::PhIdle))
    else $error("terminator did not return decoder to idle");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == csed_pkg::PhIdle)
    |-> (state_q.delay_count == '0) && (state_q.octal_value == '0))
    else $error("idle decoder holds stale string state");

  a_term_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("terminator result carries a nonzero byte");

  a_pad_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[14:8] == 7'd0))
    else $error("padding count on a data result");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 8;
  localparam int HoldCycles   = 64;
  localparam int PhaseChars   = 180;
  localparam int MaxReports   = 40;

  // characters that select a backslash escape
  localparam logic [8:0][7:0] EscKeys = {
    csed_pkg::ChLowerF, csed_pkg::ChLowerB, csed_pkg::ChLowerT, csed_pkg::ChLowerR,
    csed_pkg::ChLowerN, csed_pkg::ChColon, csed_pkg::ChBackslash, csed_pkg::ChCaret,
    csed_pkg::ChUpperE};

  typedef struct {
    logic [7:0] ch;
    logic       start;
  } char_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        pad_limit_we_i = 1'b0;
  logic [6:0]  pad_limit_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // characters waiting to be sent and decoded results still to arrive
  char_item_t        pending_q[$];
  csed_pkg::result_t decoded_q[$];
  csed_pkg::result_t step_out[$];

  // decoder copy
  csed_pkg::phase_e dec_phase = csed_pkg::PhIdle;
  logic [6:0]       dec_delay = '0;
  logic [7:0]       dec_octal = '0;
  logic [6:0]       limit_copy = 7'd100;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  bit  ch_taken = 1'b0;
  bit  mark_next = 1'b0;
  int  cycle_count = 0;
  int  fail_count = 0;
  int  chars_taken = 0;
  int  results_seen = 0;
  int  string_chars = 0;
  int  strings_made = 0;
  logic [6:0] mid_limit;

  capability_string_escape_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pad_limit_we_i (pad_limit_we_i),
    .pad_limit_i    (pad_limit_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .m_axis_tuser   (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= csed_pkg::ChZero) && (c <= csed_pkg::ChNine);
  endfunction

  // random decimal digit character from 0 up to top
  function automatic logic [7:0] rand_digit(input int unsigned top);
    return 8'(csed_pkg::ChZero + $urandom_range(top));
  endfunction

  task automatic emit_result(input logic [7:0] b, input logic [6:0] pad, input logic eos);
    csed_pkg::result_t r;
    r.out_byte      = b;
    r.pad_count     = pad;
    r.end_of_string = eos;
    r.last_of_item  = 1'b0;
    step_out.push_back(r);
  endtask

  // terminator carries the clamped delay, then the string is closed
  task automatic close_string();
    emit_result(8'h00, (dec_delay < limit_copy) ? dec_delay : limit_copy, 1'b1);
    dec_phase = csed_pkg::PhIdle;
    dec_delay = '0;
    dec_octal = '0;
  endtask

  task automatic decode_body(input logic [7:0] ch);
    if (ch == csed_pkg::ChNul || ch == csed_pkg::ChColon) begin
      close_string();
    end else if (ch == csed_pkg::ChCaret) begin
      dec_phase = csed_pkg::PhCaret;
    end else if (ch == csed_pkg::ChBackslash) begin
      dec_phase = csed_pkg::PhBsl;
    end else begin
      dec_phase = csed_pkg::PhBody;
      emit_result(ch, '0, 1'b0);
    end
  endtask

  // decode one accepted character and queue the results it causes
  task automatic decode_char(input logic [7:0] ch, input logic start);
    int unsigned       acc;
    logic [7:0]        digit;
    logic [7:0]        mapped;
    csed_pkg::result_t r;
    step_out.delete();
    digit = ch - csed_pkg::ChZero;
    if (start) begin
      dec_phase = csed_pkg::PhDigits;
      dec_delay = '0;
      dec_octal = '0;
    end
    case (dec_phase)
      csed_pkg::PhDigits: begin
        if (is_digit(ch)) begin
          acc = dec_delay * 10 + digit;
          dec_delay = (acc > csed_pkg::DelayMax) ? csed_pkg::DelayMax : acc[6:0];
        end else begin
          decode_body(ch);
        end
      end
      csed_pkg::PhBody: decode_body(ch);
      csed_pkg::PhCaret: begin
        if (ch == csed_pkg::ChNul) begin
          close_string();
        end else begin
          dec_phase = csed_pkg::PhBody;
          emit_result(ch & csed_pkg::CaretMask, '0, 1'b0);
        end
      end
      csed_pkg::PhBsl: begin
        if (ch == csed_pkg::ChNul) begin
          close_string();
        end else if (is_digit(ch)) begin
          dec_octal = digit;
          dec_phase = csed_pkg::PhOct1;
        end else begin
          case (ch)
            csed_pkg::ChUpperE: mapped = csed_pkg::CtlEsc;
            csed_pkg::ChLowerN: mapped = csed_pkg::CtlLf;
            csed_pkg::ChLowerR: mapped = csed_pkg::CtlCr;
            csed_pkg::ChLowerT: mapped = csed_pkg::CtlTab;
            csed_pkg::ChLowerB: mapped = csed_pkg::CtlBs;
            csed_pkg::ChLowerF: mapped = csed_pkg::CtlFf;
            default:            mapped = ch;
          endcase
          dec_phase = csed_pkg::PhBody;
          emit_result(mapped, '0, 1'b0);
        end
      end
      csed_pkg::PhOct1: begin
        // second position takes any character except a zero byte
        if (ch == csed_pkg::ChNul) begin
          close_string();
        end else begin
          dec_octal = (dec_octal << 3) | digit;
          dec_phase = csed_pkg::PhOct2;
        end
      end
      csed_pkg::PhOct2: begin
        if (is_digit(ch)) begin
          dec_octal = (dec_octal << 3) | digit;
          dec_phase = csed_pkg::PhBody;
          emit_result(dec_octal, '0, 1'b0);
        end else begin
          emit_result(dec_octal, '0, 1'b0);
          decode_body(ch);
        end
      end
      default: dec_phase = csed_pkg::PhIdle;
    endcase
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.last_of_item = 1'b1;
      step_out.push_back(r);
    end
    foreach (step_out[i]) decoded_q.push_back(step_out[i]);
  endtask

  task automatic push_item(input logic [7:0] c, input logic s);
    char_item_t it;
    it.ch    = c;
    it.start = s;
    pending_q.push_back(it);
  endtask

  // string character; the first one after a new string carries the start mark
  task automatic put_char(input logic [7:0] c);
    push_item(c, mark_next);
    mark_next = 1'b0;
    string_chars++;
  endtask

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == csed_pkg::ChColon || c == csed_pkg::ChCaret ||
               c == csed_pkg::ChBackslash);
    return c;
  endfunction

  // well-formed string with random content, sometimes cut short or left open
  task automatic add_random_string();
    int         n_lead;
    int         n_tok;
    int         kind;
    int         k;
    bit         cut;
    logic [7:0] c;
    mark_next = 1'b1;
    strings_made++;
    cut = 1'b0;
    kind = $urandom_range(99);
    n_lead = (kind < 40) ? 0 : (kind < 80) ? $urandom_range(1, 2) : $urandom_range(3, 5);
    for (k = 0; k < n_lead; k++) put_char(rand_digit(9));
    n_tok = $urandom_range(8);
    for (k = 0; k < n_tok && !cut; k++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        put_char(rand_plain());
      end else if (kind < 50) begin
        put_char(csed_pkg::ChCaret);
        put_char(8'($urandom_range(1, 255)));
      end else if (kind < 68) begin
        put_char(csed_pkg::ChBackslash);
        put_char(($urandom_range(3) == 0) ? rand_plain() : EscKeys[4'($urandom_range(8))]);
      end else if (kind < 92) begin
        put_char(csed_pkg::ChBackslash);
        put_char(rand_digit(9));
        put_char(($urandom_range(3) == 0) ? rand_plain() : rand_digit(7));
        if ($urandom_range(1)) put_char(rand_digit(9));
      end else begin
        // escape broken off by a zero byte, which ends the string
        c = 8'($urandom_range(2));
        put_char((c == 8'd0) ? csed_pkg::ChCaret : csed_pkg::ChBackslash);
        if (c == 8'd2) put_char(rand_digit(9));
        put_char(csed_pkg::ChNul);
        cut = 1'b1;
      end
    end
    if (!cut) begin
      kind = $urandom_range(99);
      // a few strings stay open and get restarted by the next start mark
      if (kind >= 6) put_char((kind < 55) ? csed_pkg::ChColon : csed_pkg::ChNul);
    end
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) push_item(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_pad_limit(input logic [6:0] v);
    @(negedge clk_i);
    pad_limit_i    <= v;
    pad_limit_we_i <= 1'b1;
    limit_copy = v;
    @(negedge clk_i);
    pad_limit_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // input driver: next character goes out once the current one is taken
  always @(negedge clk_i) begin : drive_chars
    char_item_t nxt;
    if (!s_axis_tvalid || ch_taken) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_q.pop_front();
        s_axis_tdata  <= nxt.ch;
        s_axis_tuser  <= nxt.start;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output ready, with random stalls and the long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on input transfers, compare on output transfers
  always @(posedge clk_i) begin : watch
    csed_pkg::result_t want;
    cycle_count++;
    ch_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (ch_taken) begin
      chars_taken++;
      decode_char(s_axis_tdata, s_axis_tuser);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("%0t: unexpected result: expected none, got byte %h pad %0d eos %b last %b",
                   $time, m_axis_tdata[7:0], m_axis_tdata[14:8], m_axis_tlast, m_axis_tuser);
        end
      end else begin
        want = decoded_q.pop_front();
        if (want.out_byte !== m_axis_tdata[7:0] || want.pad_count !== m_axis_tdata[14:8] ||
            want.end_of_string !== m_axis_tlast || want.last_of_item !== m_axis_tuser) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("%0t: expected byte %h pad %0d eos %b last %b,",
                     $time, want.out_byte, want.pad_count, want.end_of_string,
                     want.last_of_item);
            $display("    got byte %h pad %0d eos %b last %b",
                     m_axis_tdata[7:0], m_axis_tdata[14:8], m_axis_tlast, m_axis_tuser);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, decoded_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int         ph;
    int         target;
    logic [6:0] lim;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed strings at the reset pad limit
    push_item("A", 1'b0);
    mark_next = 1'b1;
    put_char("9"); put_char("9"); put_char("9");
    put_char(8'hFF);
    put_char(csed_pkg::ChCaret); put_char("G");
    put_char(csed_pkg::ChBackslash); put_char(csed_pkg::ChUpperE);
    put_char(csed_pkg::ChBackslash); put_char(csed_pkg::ChLowerN);
    put_char(csed_pkg::ChBackslash); put_char(csed_pkg::ChColon);
    put_char(csed_pkg::ChBackslash); put_char("1"); put_char("7"); put_char("7");
    put_char(csed_pkg::ChBackslash); put_char("2"); put_char("A");
    put_char(csed_pkg::ChColon);
    mark_next = 1'b1;
    put_char("5"); put_char("x");
    mark_next = 1'b1;
    put_char("Z"); put_char(csed_pkg::ChCaret); put_char(csed_pkg::ChNul);
    wait_idle();

    // random strings under several pad limits and flow patterns
    mid_limit = 7'($urandom_range(1, 126));
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  lim = 7'd0;   end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  lim = 7'd127; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; lim = mid_limit; end
        3: begin send_idle_pct = 37; recv_stall_pct = 37; lim = 7'd1;   end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; lim = 7'd100; end
      endcase
      write_pad_limit(lim);
      target = string_chars + PhaseChars;
      while (string_chars < target) add_random_string();
      // last phase: output held off while input keeps coming
      if (ph == 4) hold_req = 1'b1;
      wait_idle();
    end

    $display("decoded %0d strings: %0d characters taken, %0d results checked",
             strings_made, chars_taken, results_seen);
    $display("pad limits 100, 0, 127, %0d, 1, 100; idle, stalled and held-off streams",
             mid_limit);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
